// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher: the input operation
// codes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

	// Width and depth of the RC4 permutation.
	localparam int unsigned PERM_W     = 8;
	localparam int unsigned PERM_DEPTH = 256;

	// Operation codes carried on the op input.
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// Commands from the controller; at most one of the step commands is high.
	typedef struct packed {
		logic key_wr;      // store the incoming key byte
		logic key_restart; // the key byte opens a new key
		logic perm_init;   // write S[n] = n and clear the schedule counters
		logic ksa_rd_n;    // read S[n] and the key byte at the key position
		logic ksa_rd_acc;  // update the accumulator and read S[acc]
		logic ksa_wr_n;    // write S[n] = S[acc]
		logic ksa_wr_acc;  // write S[acc] = S[n] and advance n
		logic prga_rd_i;   // take the data byte, advance i and read S[i]
		logic prga_rd_j;   // advance j and read S[j]
		logic prga_wr_i;   // write S[i] = S[j] and read S[S[i] + S[j]]
		logic prga_out;    // write S[j] = S[i] and load the result
	} rc4_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic n_last;   // the schedule counter stands at its last entry
		logic out_free; // the result register can take a result this cycle
		logic msg_last; // the data byte in work ends the message
	} rc4_sts_t;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// Key bytes are taken while idle; a key byte marked last then stalls intake
// while the permutation is filled and its 256 entries are scrambled (states
// KA to KD per entry). After a data byte is taken, intake stalls through
// states D2, D3 and D4, set by the single write and single read port of the
// permutation memory, and D4 waits while a held result still occupies the
// output register; the result is loaded in D4. A data byte marked last adds
// the key schedule rerun. Reset clears the key state, indices and output
// valid; the key and permutation memories are not cleared.
// ----------------------------------------------------------------------------
module rc4_stream_cipher import rc4_pkg::*; #(
	parameter int unsigned KEY_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] byte_in,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic       end_of_message
);

	// The controller decides what happens to each input transfer and steps
	// the datapath one memory access at a time; the datapath owns both
	// memories, the RC4 indices and the result register, which lets a
	// finished result wait for its output transfer on its own.
	rc4_cmd_t cmd;
	rc4_sts_t sts;

	rc4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.last     (last),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Data that arrives before a key is ready is accepted and dropped by the
	// controller, which issues no datapath step for it.
	rc4_dpath #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.byte_in        (byte_in),
		.last           (last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_out       (byte_out),
		.end_of_message (end_of_message)
	);

endmodule

// ===== rtl/rc4_dpath.sv =====
// ----------------------------------------------------------------------------
// rc4_dpath
// Datapath of the RC4 cipher: key memory, permutation memory, the schedule
// and generator indices, and the result register.
// ----------------------------------------------------------------------------
module rc4_dpath import rc4_pkg::*; #(
	parameter int unsigned KEY_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rc4_cmd_t          cmd,
	output rc4_sts_t          sts,
	input  logic [7:0]        byte_in,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        byte_out,
	output logic              end_of_message
);

	localparam int unsigned CW   = $clog2(KEY_DEPTH + 1);
	localparam int unsigned KA_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam logic [CW-1:0] KEY_DEPTH_C = CW'(KEY_DEPTH);

	// Memories.
	logic [PERM_W-1:0] perm_mem [PERM_DEPTH];
	logic [7:0]        key_mem  [KEY_DEPTH];

	logic [PERM_W-1:0] perm_rd_q;
	logic [7:0]        key_rd_q;

	// Control registers.
	logic [PERM_W-1:0] n_q;
	logic [PERM_W-1:0] i_q;
	logic [PERM_W-1:0] j_q;
	logic [PERM_W-1:0] acc_q;
	logic [KA_W-1:0]   kpos_q;
	logic [CW-1:0]     key_count_q;
	logic              out_valid_q;

	// Payload registers.
	logic [7:0]        data_q;
	logic              last_q;
	logic [PERM_W-1:0] si_q;
	logic [PERM_W-1:0] sj_q;
	logic [PERM_W-1:0] t_q;
	logic [7:0]        byte_out_q;
	logic              eom_q;

	// Memory port controls.
	logic              perm_we;
	logic [PERM_W-1:0] perm_waddr;
	logic [PERM_W-1:0] perm_wdata;
	logic              perm_re;
	logic [PERM_W-1:0] perm_raddr;

	logic [CW-1:0]     key_eff;
	logic              key_we;
	logic [PERM_W-1:0] kb;
	logic [PERM_W-1:0] acc_next;
	logic [PERM_W-1:0] i_next;
	logic [PERM_W-1:0] j_next;
	logic [PERM_W-1:0] t_next;
	logic [CW-1:0]     kpos_inc;
	logic [PERM_W-1:0] ks;

	assign key_eff  = cmd.key_restart ? '0 : key_count_q;
	assign key_we   = cmd.key_wr && (key_eff < KEY_DEPTH_C);
	assign kb       = (key_count_q == '0) ? '0 : key_rd_q;
	assign acc_next = acc_q + perm_rd_q + kb;
	assign i_next   = i_q + PERM_W'(1);
	assign j_next   = j_q + perm_rd_q;
	assign t_next   = si_q + perm_rd_q;
	assign kpos_inc = CW'(kpos_q) + CW'(1);

	// The swap has already been written (or is being written) when the
	// keystream byte is picked, so the two swapped entries are forwarded.
	always_comb begin
		priority if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = perm_rd_q;
		end
	end

	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = n_q;
		perm_wdata = n_q;
		perm_re    = 1'b0;
		perm_raddr = n_q;
		priority if (cmd.perm_init) begin
			perm_we = 1'b1;
		end else if (cmd.ksa_rd_n) begin
			perm_re = 1'b1;
		end else if (cmd.ksa_rd_acc) begin
			perm_re    = 1'b1;
			perm_raddr = acc_next;
		end else if (cmd.ksa_wr_n) begin
			perm_we    = 1'b1;
			perm_wdata = perm_rd_q;
		end else if (cmd.ksa_wr_acc) begin
			perm_we    = 1'b1;
			perm_waddr = acc_q;
			perm_wdata = si_q;
		end else if (cmd.prga_rd_i) begin
			perm_re    = 1'b1;
			perm_raddr = i_next;
		end else if (cmd.prga_rd_j) begin
			perm_re    = 1'b1;
			perm_raddr = j_next;
		end else if (cmd.prga_wr_i) begin
			perm_we    = 1'b1;
			perm_waddr = i_q;
			perm_wdata = perm_rd_q;
			perm_re    = 1'b1;
			perm_raddr = t_next;
		end else if (cmd.prga_out) begin
			perm_we    = 1'b1;
			perm_waddr = j_q;
			perm_wdata = si_q;
		end
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		if (perm_re) begin
			perm_rd_q <= perm_mem[perm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_eff[KA_W-1:0]] <= byte_in;
		end
		if (cmd.ksa_rd_n) begin
			key_rd_q <= key_mem[kpos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			acc_q       <= '0;
			kpos_q      <= '0;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.key_wr) begin
				key_count_q <= key_we ? key_eff + CW'(1) : key_eff;
			end
			if (cmd.perm_init) begin
				n_q    <= n_q + PERM_W'(1);
				i_q    <= '0;
				j_q    <= '0;
				acc_q  <= '0;
				kpos_q <= '0;
			end
			if (cmd.ksa_rd_acc) begin
				acc_q <= acc_next;
			end
			if (cmd.ksa_wr_acc) begin
				n_q <= n_q + PERM_W'(1);
				if (kpos_inc >= key_count_q) begin
					kpos_q <= '0;
				end else begin
					kpos_q <= kpos_inc[KA_W-1:0];
				end
			end
			if (cmd.prga_rd_i) begin
				i_q <= i_next;
			end
			if (cmd.prga_rd_j) begin
				j_q <= j_next;
			end
			if (cmd.prga_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prga_rd_i) begin
			data_q <= byte_in;
			last_q <= last;
		end
		if (cmd.ksa_rd_acc || cmd.prga_rd_j) begin
			si_q <= perm_rd_q;
		end
		if (cmd.prga_wr_i) begin
			sj_q <= perm_rd_q;
			t_q  <= t_next;
		end
		if (cmd.prga_out) begin
			byte_out_q <= data_q ^ ks;
			eom_q      <= last_q;
		end
	end

	assign sts.n_last   = (n_q == PERM_W'(PERM_DEPTH - 1));
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.msg_last = last_q;

	assign out_valid      = out_valid_q;
	assign byte_out       = byte_out_q;
	assign end_of_message = eom_q;

`ifndef NO_ASSERTIONS
	// A result is only loaded into a free result register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prga_out |-> sts.out_free)
		else $error("result loaded while the result register was occupied");

	// The key length never exceeds the key memory depth.
	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KEY_DEPTH_C)
		else $error("key count beyond key memory depth");
`endif

endmodule

// ===== rtl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4_ctrl
// Controller of the RC4 cipher: takes input transfers, tracks the key state,
// and sequences the key schedule and the per-byte generator steps.
// ----------------------------------------------------------------------------
module rc4_ctrl import rc4_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     op,
	input  logic     last,
	output rc4_cmd_t cmd,
	input  rc4_sts_t sts
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_KA   = 4'd2;
	localparam logic [3:0] ST_KB   = 4'd3;
	localparam logic [3:0] ST_KC   = 4'd4;
	localparam logic [3:0] ST_KD   = 4'd5;
	localparam logic [3:0] ST_D2   = 4'd6;
	localparam logic [3:0] ST_D3   = 4'd7;
	localparam logic [3:0] ST_D4   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       key_open_q;
	logic       key_open_d;
	logic       key_ready_q;
	logic       key_ready_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		key_open_d  = key_open_q;
		key_ready_d = key_ready_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (op == OP_KEY) begin
						cmd.key_wr      = 1'b1;
						cmd.key_restart = !key_open_q;
						key_ready_d     = 1'b0;
						key_open_d      = !last;
						if (last) begin
							state_d = ST_INIT;
						end
					end else if (key_ready_q) begin
						cmd.prga_rd_i = 1'b1;
						state_d       = ST_D2;
					end
				end
			end
			ST_INIT: begin
				cmd.perm_init = 1'b1;
				if (sts.n_last) begin
					state_d = ST_KA;
				end
			end
			ST_KA: begin
				cmd.ksa_rd_n = 1'b1;
				state_d      = ST_KB;
			end
			ST_KB: begin
				cmd.ksa_rd_acc = 1'b1;
				state_d        = ST_KC;
			end
			ST_KC: begin
				cmd.ksa_wr_n = 1'b1;
				state_d      = ST_KD;
			end
			ST_KD: begin
				cmd.ksa_wr_acc = 1'b1;
				if (sts.n_last) begin
					key_ready_d = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_KA;
				end
			end
			ST_D2: begin
				cmd.prga_rd_j = 1'b1;
				state_d       = ST_D3;
			end
			ST_D3: begin
				cmd.prga_wr_i = 1'b1;
				state_d       = ST_D4;
			end
			ST_D4: begin
				if (sts.out_free) begin
					cmd.prga_out = 1'b1;
					state_d      = sts.msg_last ? ST_INIT : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_open_q  <= 1'b0;
			key_ready_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			key_open_q  <= key_open_d;
			key_ready_q <= key_ready_d;
		end
	end

`ifndef NO_ASSERTIONS
	// An open key is never usable for data.
	a_open_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		key_open_q |-> !key_ready_q)
		else $error("key open while marked ready");

	// The last scramble step makes the key usable.
	a_sched_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KD && sts.n_last) |=> (key_ready_q && state_q == ST_IDLE))
		else $error("key schedule finished without readying the key");

	// Datapath step commands never overlap.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.key_wr, cmd.perm_init, cmd.ksa_rd_n, cmd.ksa_rd_acc,
			cmd.ksa_wr_n, cmd.ksa_wr_acc, cmd.prga_rd_i, cmd.prga_rd_j,
			cmd.prga_wr_i, cmd.prga_out}))
		else $error("overlapping datapath commands");
`endif

endmodule
